@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/tha_pkg.sv @@
// Shared widths, register codes and constants of the track hit aggregator
`timescale 1ns / 1ps

package tha_pkg;

    localparam int ID_W     = 31;
    localparam int POS_W    = 16;
    localparam int ENERGY_W = 24;
    localparam int STEP_W   = 16;
    localparam int SUM_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int ION_W    = 27;
    localparam int LIMIT_W  = 15;
    localparam int TAN_W    = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIMARY_ONLY = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_CENTER_Z     = 3'd2,
        CFG_Y_LIMIT      = 3'd3,
        CFG_RADIUS_LIMIT = 3'd4,
        CFG_CONE_TANGENT = 3'd5
    } t_cfg_idx;

    // Register values after reset
    localparam logic                    RST_PRIMARY_ONLY = 1'b1;
    localparam logic signed [POS_W-1:0] RST_CENTER_Y     = 16'sd80;
    localparam logic signed [POS_W-1:0] RST_CENTER_Z     = 16'sd822;
    localparam logic [LIMIT_W-1:0]      RST_Y_LIMIT      = 15'd320;
    localparam logic [LIMIT_W-1:0]      RST_RADIUS_LIMIT = 15'd510;
    localparam logic [TAN_W-1:0]        RST_CONE_TANGENT = 16'd37838;

    // One ion pair per 38 eV: floor(e / 38) = floor((e >> 1) / 19),
    // taken as ((e >> 1) * ceil(2^36 / 19)) >> 36, exact for 31-bit operands
    localparam logic [5:0]       ION_PAIR_EV = 6'd38;
    localparam logic [31:0]      ION_RECIP   = 32'd3616814566;
    localparam int               ION_SHIFT   = 36;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

@@ src/tha_hit_if.sv @@
// Handshake channel carrying one detector hit or a flush command
`timescale 1ns / 1ps

interface tha_hit_if;
    import tha_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [ID_W-1:0]         event_id;
    logic [ID_W-1:0]         track_id;
    logic                    particle_match;
    logic                    from_decay;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] z_pos;
    logic [ENERGY_W-1:0]     energy;
    logic [STEP_W-1:0]       step_length;

    modport source (
        output valid, cmd, event_id, track_id, particle_match, from_decay,
               x_pos, y_pos, z_pos, energy, step_length,
        input  ready
    );
    modport sink (
        input  valid, cmd, event_id, track_id, particle_match, from_decay,
               x_pos, y_pos, z_pos, energy, step_length,
        output ready
    );
endinterface

@@ src/tha_trk_if.sv @@
// Handshake channel carrying one closed track record
`timescale 1ns / 1ps

interface tha_trk_if;
    import tha_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    out_event;
    logic [ID_W-1:0]    out_track;
    logic [SUM_W-1:0]   total_energy;
    logic [COUNT_W-1:0] hit_count;
    logic [SUM_W-1:0]   track_length;
    logic [ION_W-1:0]   ion_pairs;
    logic               contained;

    modport source (
        output valid, out_event, out_track, total_energy, hit_count,
               track_length, ion_pairs, contained,
        input  ready
    );
    modport sink (
        input  valid, out_event, out_track, total_energy, hit_count,
               track_length, ion_pairs, contained,
        output ready
    );
endinterface

@@ src/track_hit_aggregator.sv @@
// Top level: groups a stream of detector hits into per-track records
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   i_hit  : valid/ready channel of hits; cmd = 1 is a flush of the open track.
//            A transaction completes when valid and ready are both high.
//   o_trk  : valid/ready channel of closed-track records.
//   i_cfg_*: write port for the six registers; write only while idle.
// Hits of the wrong particle, or non-decay hits while primary_only is set,
// are dropped as they are taken in and never enter the pipeline.
// Pipeline: input register, containment products, track state update,
// output register (ion pair count formed on the way in). A closing hit or
// flush passes r1 and r2, then its record r3 and r4, before o_trk shows it.
// Throughput: one transaction per cycle on each side while o_trk is not
// stalled, set by the single track-state register that each hit updates once.
// Reset clears all pipeline valid bits and the open track, and returns the
// registers to their defaults. When the receiver stalls, each stage holds
// while its successor is full; ready ripples back to i_hit, so a bubble
// anywhere in the four stages still lets a new hit in.
module track_hit_aggregator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tha_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tha_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    tha_hit_if.sink                           i_hit,
    tha_trk_if.source                         o_trk
);
    import tha_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                    r_primary_only;
    logic signed [POS_W-1:0] r_center_y;
    logic signed [POS_W-1:0] r_center_z;
    logic [LIMIT_W-1:0]      r_y_limit;
    logic [LIMIT_W-1:0]      r_radius_limit;
    logic [TAN_W-1:0]        r_cone_tangent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary_only <= RST_PRIMARY_ONLY;
            r_center_y     <= RST_CENTER_Y;
            r_center_z     <= RST_CENTER_Z;
            r_y_limit      <= RST_Y_LIMIT;
            r_radius_limit <= RST_RADIUS_LIMIT;
            r_cone_tangent <= RST_CONE_TANGENT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PRIMARY_ONLY: r_primary_only <= i_cfg_data[0];
                CFG_CENTER_Y:     r_center_y     <= i_cfg_data;
                CFG_CENTER_Z:     r_center_z     <= i_cfg_data;
                CFG_Y_LIMIT:      r_y_limit      <= i_cfg_data[LIMIT_W-1:0];
                CFG_RADIUS_LIMIT: r_radius_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_CONE_TANGENT: r_cone_tangent <= i_cfg_data[TAN_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage may load when it is empty or draining
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_fire, keep, adv2, emit, adv3;

    assign rdy4 = !r_v4 || o_trk.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_hit.ready = rdy1;
    assign in_fire     = i_hit.valid && rdy1;

    // Drop hits that fail the particle or process filter on entry
    assign keep = i_hit.cmd ||
                  (i_hit.particle_match && (!r_primary_only || i_hit.from_decay));

    assign adv2 = r_v2 && rdy3;
    assign adv3 = r_v3 && rdy4;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                    r1_cmd;
    logic [ID_W-1:0]         r1_event, r1_track;
    logic signed [POS_W-1:0] r1_x, r1_y, r1_z;
    logic [ENERGY_W-1:0]     r1_energy;
    logic [STEP_W-1:0]       r1_step;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_cmd    <= i_hit.cmd;
            r1_event  <= i_hit.event_id;
            r1_track  <= i_hit.track_id;
            r1_x      <= i_hit.x_pos;
            r1_y      <= i_hit.y_pos;
            r1_z      <= i_hit.z_pos;
            r1_energy <= i_hit.energy;
            r1_step   <= i_hit.step_length;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: offsets and the products of the containment test
    // ------------------------------------------------------------------
    logic signed [POS_W:0]     dy, dz, dx_ext;
    logic [POS_W:0]            ady_full, adx_full, ndz_full;
    logic signed [2*POS_W-1:0] sq_dx_full;
    logic signed [2*POS_W+1:0] sq_dz_full;
    logic [2*LIMIT_W-1:0]      r_sq_full;
    logic [SUM_W-1:0]          cone_rhs;

    always_comb begin
        dy       = $signed({r1_y[POS_W-1], r1_y}) - $signed({r_center_y[POS_W-1], r_center_y});
        dz       = $signed({r1_z[POS_W-1], r1_z}) - $signed({r_center_z[POS_W-1], r_center_z});
        dx_ext   = $signed({r1_x[POS_W-1], r1_x});
        ady_full = dy[POS_W] ? (17'd0 - dy) : dy;
        adx_full = dx_ext[POS_W] ? (17'd0 - dx_ext) : dx_ext;
        ndz_full = 17'd0 - dz;
        sq_dx_full = r1_x * r1_x;
        sq_dz_full = dz * dz;
        r_sq_full  = r_radius_limit * r_radius_limit;
        cone_rhs   = r_cone_tangent * ndz_full[POS_W-1:0];
    end

    logic                    r2_cmd;
    logic [ID_W-1:0]         r2_event, r2_track;
    logic [ENERGY_W-1:0]     r2_energy;
    logic [STEP_W-1:0]       r2_step;
    logic                    r2_y_ok;
    logic                    r2_dz_neg;
    logic [2*POS_W-2:0]      r2_sq_dx;
    logic [2*POS_W-1:0]      r2_sq_dz;
    logic [2*LIMIT_W-1:0]    r2_r_sq;
    logic [POS_W-1:0]        r2_adx;
    logic [SUM_W-1:0]        r2_cone_rhs;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_cmd      <= r1_cmd;
            r2_event    <= r1_event;
            r2_track    <= r1_track;
            r2_energy   <= r1_energy;
            r2_step     <= r1_step;
            r2_y_ok     <= ady_full[POS_W-1:0] <= {1'b0, r_y_limit};
            r2_dz_neg   <= dz[POS_W];
            r2_sq_dx    <= sq_dx_full[2*POS_W-2:0];
            r2_sq_dz    <= sq_dz_full[2*POS_W-1:0];
            r2_r_sq     <= r_sq_full;
            r2_adx      <= adx_full[POS_W-1:0];
            r2_cone_rhs <= cone_rhs;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: containment verdict and the open-track state update
    // ------------------------------------------------------------------
    logic                 r_track_open, n_track_open;
    logic [ID_W-1:0]      r_open_event, n_open_event;
    logic [ID_W-1:0]      r_open_track, n_open_track;
    logic [SUM_W-1:0]     r_energy_sum, n_energy_sum;
    logic [COUNT_W-1:0]   r_hits_seen, n_hits_seen;
    logic [SUM_W-1:0]     r_length_sum, n_length_sum;
    logic                 r_all_inside, n_all_inside;

    logic [SUM_W:0]       ring_sum;
    logic                 ring, cone, hit_ok, same;
    logic [SUM_W-1:0]     base_energy, base_length;
    logic [COUNT_W-1:0]   base_hits;
    logic                 base_inside;
    logic [SUM_W:0]       energy_add, length_add;

    always_comb begin
        ring_sum = {2'b00, r2_sq_dx} + {1'b0, r2_sq_dz};
        ring     = ring_sum <= {3'b000, r2_r_sq};
        cone     = r2_dz_neg && ({r2_adx, 16'd0} <= r2_cone_rhs);
        hit_ok   = r2_y_ok && (ring || cone);
        same     = r_track_open && (r2_event == r_open_event) &&
                   (r2_track == r_open_track);

        // Start from the open track when the hit continues it, else from empty
        base_energy = same ? r_energy_sum : '0;
        base_length = same ? r_length_sum : '0;
        base_hits   = same ? r_hits_seen  : '0;
        base_inside = same ? r_all_inside : 1'b1;
        energy_add  = {1'b0, base_energy} + {{(SUM_W+1-ENERGY_W){1'b0}}, r2_energy};
        length_add  = {1'b0, base_length} + {{(SUM_W+1-STEP_W){1'b0}}, r2_step};

        n_track_open = r_track_open;
        n_open_event = r_open_event;
        n_open_track = r_open_track;
        n_energy_sum = r_energy_sum;
        n_hits_seen  = r_hits_seen;
        n_length_sum = r_length_sum;
        n_all_inside = r_all_inside;
        emit         = 1'b0;

        if (adv2) begin
            if (r2_cmd) begin
                // Flush: close the open track, if any
                emit         = r_track_open;
                n_track_open = 1'b0;
                n_open_event = '0;
                n_open_track = '0;
                n_energy_sum = '0;
                n_hits_seen  = '0;
                n_length_sum = '0;
                n_all_inside = 1'b1;
            end else begin
                emit         = r_track_open && !same;
                n_track_open = 1'b1;
                n_open_event = r2_event;
                n_open_track = r2_track;
                n_energy_sum = energy_add[SUM_W] ? '1 : energy_add[SUM_W-1:0];
                n_length_sum = length_add[SUM_W] ? '1 : length_add[SUM_W-1:0];
                n_hits_seen  = (base_hits == COUNT_MAX) ? base_hits :
                               base_hits + 1'b1;
                n_all_inside = base_inside && hit_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_open <= 1'b0;
            r_open_event <= '0;
            r_open_track <= '0;
            r_energy_sum <= '0;
            r_hits_seen  <= '0;
            r_length_sum <= '0;
            r_all_inside <= 1'b1;
        end else begin
            r_track_open <= n_track_open;
            r_open_event <= n_open_event;
            r_open_track <= n_open_track;
            r_energy_sum <= n_energy_sum;
            r_hits_seen  <= n_hits_seen;
            r_length_sum <= n_length_sum;
            r_all_inside <= n_all_inside;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: closed-track record
    // ------------------------------------------------------------------
    logic [ID_W-1:0]    r3_event, r3_track;
    logic [SUM_W-1:0]   r3_energy, r3_length;
    logic [COUNT_W-1:0] r3_hits;
    logic               r3_inside;

    always_ff @(posedge i_clk) begin
        if (adv2 && emit) begin
            r3_event  <= r_open_event;
            r3_track  <= r_open_track;
            r3_energy <= r_energy_sum;
            r3_length <= r_length_sum;
            r3_hits   <= r_hits_seen;
            r3_inside <= r_all_inside;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 -> 4: ion pair count by reciprocal multiply, output register
    // ------------------------------------------------------------------
    logic [2*SUM_W-2:0] ion_prod;
    assign ion_prod = r3_energy[SUM_W-1:1] * ION_RECIP;

    logic [ID_W-1:0]    r4_event, r4_track;
    logic [SUM_W-1:0]   r4_energy, r4_length;
    logic [COUNT_W-1:0] r4_hits;
    logic [ION_W-1:0]   r4_ion;
    logic               r4_inside;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r4_event  <= r3_event;
            r4_track  <= r3_track;
            r4_energy <= r3_energy;
            r4_length <= r3_length;
            r4_hits   <= r3_hits;
            r4_ion    <= ion_prod[ION_SHIFT+ION_W-1:ION_SHIFT];
            r4_inside <= r3_inside;
        end
    end

    // Valid bits of the four stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= in_fire && keep;
            if (rdy2) r_v2 <= r_v1;
            r_v3 <= (r_v3 && !rdy4) || (adv2 && emit);
            if (rdy4) r_v4 <= r_v3;
        end
    end

    assign o_trk.valid        = r_v4;
    assign o_trk.out_event    = r4_event;
    assign o_trk.out_track    = r4_track;
    assign o_trk.total_energy = r4_energy;
    assign o_trk.hit_count    = r4_hits;
    assign o_trk.track_length = r4_length;
    assign o_trk.ion_pairs    = r4_ion;
    assign o_trk.contained    = r4_inside;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] ion_div;
    logic [SUM_W-1:0] ion_back;
    logic [SUM_W-1:0] ion_rem;
    logic             ion_ok;
    logic             closed_clr;
    assign ion_div    = {{(SUM_W-6){1'b0}}, ION_PAIR_EV};
    assign ion_back   = {{(SUM_W-ION_W){1'b0}}, r4_ion} * ion_div;
    assign ion_rem    = r4_energy - ion_back;
    assign ion_ok     = (ion_back <= r4_energy) && (ion_rem < ion_div);
    assign closed_clr = (r_hits_seen == '0) && r_all_inside;

    `ASSERT_IMPLY(a_open_has_hits, i_clk, i_rst_n, r_track_open, r_hits_seen != '0, "no hits")
    `ASSERT_IMPLY(a_closed_is_clear, i_clk, i_rst_n, !r_track_open, closed_clr, "not cleared")
    `ASSERT_IMPLY(a_record_has_hits, i_clk, i_rst_n, r_v4, r4_hits != '0, "empty record")
    `ASSERT_IMPLY(a_ion_pairs_floor, i_clk, i_rst_n, r_v4, ion_ok, "ion pairs not floor")
    `ASSERT_NEXT(a_record_kept, i_clk, i_rst_n, r_v3 && !rdy4, r_v3, "stalled record lost")

endmodule
